/* rtl/vgtb_pkg.sv */
// Package for the glyph tile blitter: command codes, pipeline stage type and row merge helper.
`default_nettype none

package vgtb_pkg;

    // Default geometry
    localparam int TILES_PER_LINE_DEF = 26;
    localparam int SCREEN_ROWS_DEF    = 32;

    // Field widths
    localparam int PEN_W    = 10;
    localparam int ROWOUT_W = 5;
    localparam logic [PEN_W-1:0] PEN_MAX = 10'h3FF;

    // Command codes
    typedef enum logic [2:0] {
        CMD_BLIT    = 3'd0,
        CMD_ADVANCE = 3'd1,
        CMD_NEWLINE = 3'd2,
        CMD_SET_ROW = 3'd3,
        CMD_READ    = 3'd4
    } cmd_t;

    // Item held between the input register and the result register
    typedef struct packed {
        logic                is_newline;
        logic                is_read;
        logic [63:0]         glyph_top;
        logic [63:0]         glyph_bottom;
        logic [2:0]          sub;
        logic                tile_lsb;
        logic                main_we;
        logic                spill_we;
        logic                rd_half;
        logic [2:0]          rd_row;
        logic                overflow;
        logic [PEN_W-1:0]    pen;
        logic [ROWOUT_W-1:0] screen;
    } stage_t;

    // AND one glyph half into one tile half (active-low rows).
    // The main write takes the ink shifted right by sub, the spill the bits shifted out.
    function automatic logic [63:0] merge_half(input logic [63:0] word,
                                               input logic [63:0] glyph,
                                               input logic [2:0]  sub,
                                               input logic        spill);
        logic [7:0]  ink;
        logic [15:0] wide;
        logic [63:0] res;
        res = word;
        for (int r = 0; r < 8; r++) begin
            ink  = ~glyph[8*r +: 8];
            wide = {ink, 8'h00} >> sub;
            res[8*r +: 8] = res[8*r +: 8] & ~(spill ? wide[7:0] : wide[15:8]);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* rtl/vwf_glyph_tile_blitter_top.sv */
// Glyph tile blitter: pen and row state, banked tile line store and two-stage pipeline.
//
// Usage: each beat on the s_ channel carries one command (blit a glyph chunk, advance
// the pen, start a new line, set the screen row, read back one stored byte). Every
// command gives exactly one beat on the m_ channel with the stored byte (inverted,
// one is ink), the pen position and screen row after the command, and the overflow
// flag for a write or read beyond the line.
// Path: a command goes through the input register, then the result register. Throughput
// is one command per cycle unless m_ready stalls; the tile store is split into even and
// odd tile banks so the tile under the pen and the spill tile are read in the accept
// cycle and written back as the command commits, with a bypass covering a command that
// reads what the one before it writes. Reset: pen, sub-tile y and screen row go to zero,
// and a valid bit per tile makes the whole store read as background at once;
// no clearing pass, a new line clears the valid bits as well.
// Stall: while m_ready is low the result register holds and the input register keeps
// its command, so s_ready drops once both are full; no command is lost or repeated.
`default_nettype none

module vwf_glyph_tile_blitter_top
    import vgtb_pkg::*;
#(
    parameter int TILES_PER_LINE = TILES_PER_LINE_DEF,
    parameter int SCREEN_ROWS    = SCREEN_ROWS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output      logic                s_ready,
    input  wire logic [2:0]          s_cmd,
    input  wire logic [63:0]         s_glyph_top,
    input  wire logic [63:0]         s_glyph_bottom,
    input  wire logic [3:0]          s_width,
    input  wire logic [7:0]          s_amount,
    input  wire logic [8:0]          s_read_index,
    output      logic                m_valid,
    input  wire logic                m_ready,
    output      logic [7:0]          m_read_data,
    output      logic [PEN_W-1:0]    m_pen_position,
    output      logic [ROWOUT_W-1:0] m_screen_row,
    output      logic                m_overflow
);

    localparam int BANK_DEPTH = (TILES_PER_LINE + 1) / 2;
    localparam int ABW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int SRW        = $clog2(SCREEN_ROWS);
    localparam int HALF_BYTES = TILES_PER_LINE * 8;

    // Screen row reduction table, built at elaboration
    typedef logic [SRW-1:0] row_tbl_t [256];

    function automatic row_tbl_t build_row_tbl();
        row_tbl_t t;
        for (int i = 0; i < 256; i++) begin
            t[i] = SRW'(i % SCREEN_ROWS);
        end
        return t;
    endfunction

    localparam row_tbl_t ROW_TBL = build_row_tbl();

    // State
    logic [PEN_W-1:0] pen_reg, pen_next;
    logic [2:0]       suby_reg, suby_next;
    logic [SRW-1:0]   scr_reg, scr_next;

    // Pipeline control
    logic   s1_valid_reg;
    stage_t s1_reg, s1_next;
    logic   out_free, commit, accept;

    // Banks
    logic [127:0]          even_mem_reg [BANK_DEPTH];
    logic [127:0]          odd_mem_reg  [BANK_DEPTH];
    logic [BANK_DEPTH-1:0] even_vld_reg, odd_vld_reg;
    logic [127:0]          even_q_reg, odd_q_reg;
    logic                  even_vq_reg, odd_vq_reg;
    logic [ABW-1:0]        even_raddr, odd_raddr, even_addr_reg, odd_addr_reg;
    logic                  even_fwd_dat_reg, odd_fwd_dat_reg;
    logic                  even_fwd_clr_reg, odd_fwd_clr_reg;
    logic [127:0]          even_fwd_word_reg, odd_fwd_word_reg;
    logic [127:0]          even_eff, odd_eff, even_wdata, odd_wdata;
    logic                  even_we, odd_we;

    // Result register
    logic                m_valid_reg;
    logic [7:0]          m_read_data_reg, m_read_data_next;
    logic [PEN_W-1:0]    m_pen_reg;
    logic [ROWOUT_W-1:0] m_screen_reg;
    logic                m_overflow_reg;

    // Decode front end
    logic                is_blit, is_adv, is_nl, is_set, is_read;
    logic [3:0]          w_clamped;
    logic [PEN_W:0]      pen_sum;
    logic [PEN_W-1:0]    pen_sat;
    logic [6:0]          tile7;
    logic [7:0]          tile_p1;
    logic                main_ok, spill_ok, spill_do;
    logic [8:0]          ysum;
    logic [7:0]          row_sum;
    logic                rd_oob, rd_half;
    logic [9:0]          rd_rem;
    logic [7:0]          addr_tile;
    logic [8:0]          even_full;
    logic [7:0]          odd_full;
    logic [63:0]         sel_word;
    logic [127:0]        sel_tile;

    // Handshake
    assign out_free = !m_valid_reg || m_ready;
    assign commit   = s1_valid_reg && out_free;
    assign s_ready  = !s1_valid_reg || out_free;
    assign accept   = s_valid && s_ready;

    // Command decode, pen arithmetic and store addressing for the incoming beat
    always_comb begin
        is_blit = (s_cmd == CMD_BLIT);
        is_adv  = (s_cmd == CMD_ADVANCE);
        is_nl   = (s_cmd == CMD_NEWLINE);
        is_set  = (s_cmd == CMD_SET_ROW);
        is_read = (s_cmd == CMD_READ);

        w_clamped = (s_width > 4'd8) ? 4'd8 : s_width;
        if (is_adv) begin
            pen_sum = {1'b0, pen_reg} + (PEN_W+1)'(s_amount) + (PEN_W+1)'(8);
        end else begin
            pen_sum = {1'b0, pen_reg} + (PEN_W+1)'(w_clamped);
        end
        pen_sat = (pen_sum > {1'b0, PEN_MAX}) ? PEN_MAX : pen_sum[PEN_W-1:0];

        tile7    = pen_reg[PEN_W-1:3];
        tile_p1  = {1'b0, tile7} + 8'd1;
        main_ok  = ({1'b0, tile7} < 8'(TILES_PER_LINE));
        spill_ok = (tile_p1 < 8'(TILES_PER_LINE));
        spill_do = (pen_sat[PEN_W-1:3] != tile7) && (pen_reg[2:0] != 3'd0);

        // Read index: half, tile, row
        rd_oob  = ({2'b0, s_read_index} >= 11'(2 * HALF_BYTES));
        rd_half = ({1'b0, s_read_index} >= 10'(HALF_BYTES));
        rd_rem  = rd_half ? ({1'b0, s_read_index} - 10'(HALF_BYTES))
                          : {1'b0, s_read_index};

        // Even bank holds tile 2a, odd bank tile 2a+1
        addr_tile = is_blit ? {1'b0, tile7} : {1'b0, rd_rem[9:3]};
        even_full = ({1'b0, addr_tile} + 9'd1) >> 1;
        odd_full  = addr_tile >> 1;
        even_raddr = (even_full < 9'(BANK_DEPTH)) ? even_full[ABW-1:0] : '0;
        odd_raddr  = (odd_full < 8'(BANK_DEPTH)) ? odd_full[ABW-1:0] : '0;

        // Next state
        ysum     = {6'b0, suby_reg} + {1'b0, s_amount};
        row_sum  = 8'(scr_reg) + {2'b0, ysum[8:3]} + 8'd1;
        pen_next  = pen_reg;
        suby_next = suby_reg;
        scr_next  = scr_reg;
        if (is_blit || is_adv) begin
            pen_next = pen_sat;
        end
        if (is_nl) begin
            pen_next  = '0;
            suby_next = ysum[2:0];
            scr_next  = ROW_TBL[row_sum];
        end
        if (is_set) begin
            scr_next = ROW_TBL[s_amount];
        end

        // Stage record
        s1_next.is_newline   = is_nl;
        s1_next.is_read      = is_read;
        s1_next.glyph_top    = s_glyph_top;
        s1_next.glyph_bottom = s_glyph_bottom;
        s1_next.sub          = pen_reg[2:0];
        s1_next.tile_lsb     = addr_tile[0];
        s1_next.main_we      = is_blit && main_ok;
        s1_next.spill_we     = is_blit && spill_do && spill_ok;
        s1_next.rd_half      = rd_half;
        s1_next.rd_row       = rd_rem[2:0];
        s1_next.overflow     = (is_blit && (!main_ok || (spill_do && !spill_ok)))
                            || (is_read && rd_oob);
        s1_next.pen          = pen_next;
        s1_next.screen       = ROWOUT_W'(scr_next);
    end

    // State registers, updated as each beat is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pen_reg      <= '0;
            suby_reg     <= '0;
            scr_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                pen_reg  <= pen_next;
                suby_reg <= suby_next;
                scr_reg  <= scr_next;
            end
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (commit) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_reg        <= s1_next;
            even_addr_reg <= even_raddr;
            odd_addr_reg  <= odd_raddr;
        end
    end

    // Effective tile words: bypass from the write-back, then valid bit, then memory
    always_comb begin
        if (even_fwd_dat_reg) begin
            even_eff = even_fwd_word_reg;
        end else if (even_fwd_clr_reg || !even_vq_reg) begin
            even_eff = '1;
        end else begin
            even_eff = even_q_reg;
        end
        if (odd_fwd_dat_reg) begin
            odd_eff = odd_fwd_word_reg;
        end else if (odd_fwd_clr_reg || !odd_vq_reg) begin
            odd_eff = '1;
        end else begin
            odd_eff = odd_q_reg;
        end
    end

    // Merge and write-back; the bank not under the pen takes the spill
    always_comb begin
        even_we = commit && (s1_reg.tile_lsb ? s1_reg.spill_we : s1_reg.main_we);
        odd_we  = commit && (s1_reg.tile_lsb ? s1_reg.main_we : s1_reg.spill_we);
        even_wdata = {merge_half(even_eff[127:64], s1_reg.glyph_bottom, s1_reg.sub,
                                 s1_reg.tile_lsb),
                      merge_half(even_eff[63:0], s1_reg.glyph_top, s1_reg.sub,
                                 s1_reg.tile_lsb)};
        odd_wdata  = {merge_half(odd_eff[127:64], s1_reg.glyph_bottom, s1_reg.sub,
                                 !s1_reg.tile_lsb),
                      merge_half(odd_eff[63:0], s1_reg.glyph_top, s1_reg.sub,
                                 !s1_reg.tile_lsb)};
    end

    // Even bank memory
    always_ff @(posedge aclk) begin
        if (even_we) begin
            even_mem_reg[even_addr_reg] <= even_wdata;
        end
        if (accept) begin
            even_q_reg <= even_mem_reg[even_raddr];
        end
    end

    // Odd bank memory
    always_ff @(posedge aclk) begin
        if (odd_we) begin
            odd_mem_reg[odd_addr_reg] <= odd_wdata;
        end
        if (accept) begin
            odd_q_reg <= odd_mem_reg[odd_raddr];
        end
    end

    // Valid bits and bypass flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            even_vld_reg     <= '0;
            odd_vld_reg      <= '0;
            even_vq_reg      <= 1'b0;
            odd_vq_reg       <= 1'b0;
            even_fwd_dat_reg <= 1'b0;
            odd_fwd_dat_reg  <= 1'b0;
            even_fwd_clr_reg <= 1'b0;
            odd_fwd_clr_reg  <= 1'b0;
        end else begin
            if (accept) begin
                even_vq_reg      <= even_vld_reg[even_raddr];
                odd_vq_reg       <= odd_vld_reg[odd_raddr];
                even_fwd_dat_reg <= even_we && (even_addr_reg == even_raddr);
                odd_fwd_dat_reg  <= odd_we && (odd_addr_reg == odd_raddr);
                even_fwd_clr_reg <= commit && s1_reg.is_newline;
                odd_fwd_clr_reg  <= commit && s1_reg.is_newline;
            end
            if (commit && s1_reg.is_newline) begin
                even_vld_reg <= '0;
                odd_vld_reg  <= '0;
            end else begin
                if (even_we) begin
                    even_vld_reg[even_addr_reg] <= 1'b1;
                end
                if (odd_we) begin
                    odd_vld_reg[odd_addr_reg] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            even_fwd_word_reg <= even_wdata;
            odd_fwd_word_reg  <= odd_wdata;
        end
    end

    // Read-back byte
    always_comb begin
        sel_tile = s1_reg.tile_lsb ? odd_eff : even_eff;
        sel_word = s1_reg.rd_half ? sel_tile[127:64] : sel_tile[63:0];
        if (s1_reg.is_read && !s1_reg.overflow) begin
            m_read_data_next = ~sel_word[8*s1_reg.rd_row +: 8];
        end else begin
            m_read_data_next = '0;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            m_read_data_reg <= m_read_data_next;
            m_pen_reg       <= s1_reg.pen;
            m_screen_reg    <= s1_reg.screen;
            m_overflow_reg  <= s1_reg.overflow;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_read_data    = m_read_data_reg;
    assign m_pen_position = m_pen_reg;
    assign m_screen_row   = m_screen_reg;
    assign m_overflow     = m_overflow_reg;

`ifndef SYNTHESIS
    // A new line leaves the whole store reading as background
    a_newline_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && s1_reg.is_newline) |=> (even_vld_reg == '0 && odd_vld_reg == '0))
        else $error("store valid bits not cleared after new line");

    // Screen row stays inside the configured range
    a_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, scr_reg} < (SRW+1)'(SCREEN_ROWS)))
        else $error("screen row out of range");

    // A taken beat always reaches the input register
    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> s1_valid_reg)
        else $error("accepted beat lost from input register");

    // A flagged result never carries read data
    a_ovf_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_overflow_reg) |-> (m_read_data_reg == 8'd0))
        else $error("read data on an overflow result");

    // No write-back while a result waits in a full output register
    a_no_commit_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> (!even_we && !odd_we))
        else $error("store written while result stalled");
`endif

endmodule

`default_nettype wire
